[rtl/core/htpm_pkg.sv]
// ============================================================================
// htpm_pkg: shared types and constants for the hardware timer pool manager
// Service codes, status codes, fixed per-timer attributes, transfer structs
// and the sequencer state encodings.
// ============================================================================
`default_nettype none

package htpm_pkg;

    localparam int NUM_TIMERS = 6;

    // processor, pixel and line clock rates in Hz
    localparam logic [63:0] IOP_HZ  = 64'd36864000;
    localparam logic [25:0] HZ_CPU  = 26'd36864000;
    localparam logic [25:0] HZ_PIX  = 26'd13500000;
    localparam logic [25:0] HZ_LINE = 26'd15734;

    localparam logic [31:0] SRC_PIX  = 32'd2;
    localparam logic [31:0] SRC_LINE = 32'd4;

    localparam logic [31:0] MODE_RUN_BIT = 32'h80000000;
    localparam logic [27:0] ADDR_MASK    = 28'hFFFFFFF;
    localparam logic [15:0] COUNT_SAT    = 16'hFFFF;
    localparam logic [63:0] ALL_ONES     = 64'hFFFFFFFFFFFFFFFF;

    // service codes
    localparam logic [4:0] OP_TABLE    = 5'd3;
    localparam logic [4:0] OP_ALLOC    = 5'd4;
    localparam logic [4:0] OP_REFER    = 5'd5;
    localparam logic [4:0] OP_FREE     = 5'd6;
    localparam logic [4:0] OP_SET_MODE = 5'd7;
    localparam logic [4:0] OP_GET_MODE = 5'd8;
    localparam logic [4:0] OP_SET_CNT  = 5'd9;
    localparam logic [4:0] OP_GET_CNT  = 5'd10;
    localparam logic [4:0] OP_SET_CMP  = 5'd11;
    localparam logic [4:0] OP_GET_CMP  = 5'd12;
    localparam logic [4:0] OP_SET_HOLD = 5'd13;
    localparam logic [4:0] OP_GET_HOLD = 5'd14;
    localparam logic [4:0] OP_HOLD_REG = 5'd15;
    localparam logic [4:0] OP_IRQ      = 5'd16;
    localparam logic [4:0] OP_MODE_ALT = 5'd17;
    localparam logic [4:0] OP_READ_FN  = 5'd18;
    localparam logic [4:0] OP_CMP_HDL  = 5'd20;
    localparam logic [4:0] OP_OVF_HDL  = 5'd21;
    localparam logic [4:0] OP_SETUP    = 5'd22;
    localparam logic [4:0] OP_START    = 5'd23;
    localparam logic [4:0] OP_STOP     = 5'd24;
    localparam logic [4:0] OP_NEXT_EVT = 5'd25;

    // status codes
    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_NO_TIMER  = 4'd1;
    localparam logic [3:0] ST_BAD_ID    = 4'd2;
    localparam logic [3:0] ST_BAD_SRC   = 4'd3;
    localparam logic [3:0] ST_BAD_PRE   = 4'd4;
    localparam logic [3:0] ST_BUSY      = 4'd5;
    localparam logic [3:0] ST_UNCONF    = 4'd6;
    localparam logic [3:0] ST_NOT_RUN   = 4'd7;
    localparam logic [3:0] ST_BAD_MODE  = 4'd8;

    typedef struct packed {
        logic [4:0]  op;
        logic [31:0] arg0;
        logic [31:0] arg1;
        logic [31:0] arg2;
        logic [31:0] arg3;
        logic [63:0] now_cycle;
        logic [63:0] fallback_cycle;
    } htpm_req_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [31:0] value;
        logic        handled;
        logic [63:0] next_event;
    } htpm_rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_RS_START,
        S_CN_START,
        S_MUL,
        S_DIV,
        S_STEP,
        S_POST,
        S_RS_NEXT,
        S_SCAN,
        S_FINISH
    } htpm_state_t;

    typedef enum logic [2:0] {
        PH_CN_P,
        PH_CN_D,
        PH_CN_Q,
        PH_TT_S,
        PH_TT_Q1,
        PH_TT_W,
        PH_TT_R,
        PH_TT_Q2
    } htpm_phase_t;

    // fixed timer attributes
    function automatic logic [31:0] tm_addr(input logic [2:0] i);
        case (i)
            3'd0:    tm_addr = 32'hBF801100;
            3'd1:    tm_addr = 32'hBF801110;
            3'd2:    tm_addr = 32'hBF801120;
            3'd3:    tm_addr = 32'hBF801480;
            3'd4:    tm_addr = 32'hBF801490;
            3'd5:    tm_addr = 32'hBF8014A0;
            default: tm_addr = 32'h0;
        endcase
    endfunction

    function automatic logic [31:0] tm_srcmask(input logic [2:0] i);
        case (i)
            3'd0:    tm_srcmask = 32'h0B;
            3'd1:    tm_srcmask = 32'h0D;
            3'd2:    tm_srcmask = 32'h01;
            3'd3:    tm_srcmask = 32'h05;
            3'd4:    tm_srcmask = 32'h01;
            3'd5:    tm_srcmask = 32'h01;
            default: tm_srcmask = 32'h0;
        endcase
    endfunction

    function automatic logic tm_is16(input logic [2:0] i);
        tm_is16 = (i < 3'd3);
    endfunction

    function automatic logic [31:0] tm_width(input logic [2:0] i);
        tm_width = tm_is16(i) ? 32'd16 : 32'd32;
    endfunction

    function automatic logic [8:0] tm_maxpre(input logic [2:0] i);
        case (i)
            3'd2:    tm_maxpre = 9'd8;
            3'd4:    tm_maxpre = 9'd256;
            3'd5:    tm_maxpre = 9'd256;
            default: tm_maxpre = 9'd1;
        endcase
    endfunction

    function automatic logic [4:0] tm_irq(input logic [2:0] i);
        case (i)
            3'd0:    tm_irq = 5'd4;
            3'd1:    tm_irq = 5'd5;
            3'd2:    tm_irq = 5'd6;
            3'd3:    tm_irq = 5'd14;
            3'd4:    tm_irq = 5'd15;
            3'd5:    tm_irq = 5'd16;
            default: tm_irq = 5'd0;
        endcase
    endfunction

    function automatic logic [2:0] alloc_ord(input logic [2:0] k);
        case (k)
            3'd0:    alloc_ord = 3'd2;
            3'd1:    alloc_ord = 3'd5;
            3'd2:    alloc_ord = 3'd4;
            3'd3:    alloc_ord = 3'd3;
            3'd4:    alloc_ord = 3'd0;
            default: alloc_ord = 3'd1;
        endcase
    endfunction

    function automatic logic [31:0] make_id(input logic [2:0] i);
        logic [31:0] a;
        a = tm_addr(i);
        make_id = {4'({1'b0, i} + 4'd1), a[31:4]};
    endfunction

    function automatic logic [25:0] src_hz(input logic [31:0] src);
        if (src == SRC_PIX)
            src_hz = HZ_PIX;
        else if (src == SRC_LINE)
            src_hz = HZ_LINE;
        else
            src_hz = HZ_CPU;
    endfunction

    function automatic logic [31:0] wmask(input logic is16, input logic [31:0] v);
        wmask = is16 ? {16'h0, v[15:0]} : v;
    endfunction

endpackage

`default_nettype wire

[rtl/core/hard_timer_pool_manager_unit.sv]
// ============================================================================
// hard_timer_pool_manager_unit: service unit for a pool of six hardware timers
// Allocation, sharing, setup, start/stop, counter/compare access and the
// next-event query, worked out by one shared shift-add multiplier and one
// restoring divider under a small sequencer.
// ============================================================================
// Usage:
//   req channel (req_valid/req_stall/req) carries one service request; rsp
//   channel (rsp_valid/rsp_stall/rsp) returns exactly one response per request.
//   A request is taken only while the sequencer is idle; req_stall is high for
//   the whole time one request is being worked.
//   Response time depends on the service: the next-event query compares one
//   due time per cycle; counter read, stop and services that reschedule a
//   running timer use the shared shift-add multiplier (one multiplier bit per
//   cycle) and the 64-step restoring divider, run in turn for the tick count
//   and for each tick-to-cycle conversion.
//   One request is in flight at a time; a finished response is held in an
//   output register, so a new request is accepted while it waits.
//   If the receiver stalls, the response holds and a finished second request
//   waits in its last state until the register frees.
//   Reset clears all timers (due cycles to all ones), hold modes and the
//   handshake state.
// ============================================================================
`default_nettype none

module hard_timer_pool_manager_unit
    import htpm_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_stall,
    input  wire htpm_req_t req,
    output logic           rsp_valid,
    input  wire logic      rsp_stall,
    output htpm_rsp_t      rsp
);

    // sequencer
    htpm_state_t state_reg, state_next;
    htpm_phase_t phase_reg, phase_next;
    htpm_req_t   in_reg, in_next;
    htpm_rsp_t   res_reg, res_next;
    htpm_rsp_t   rsp_reg, rsp_next;
    logic        rsp_valid_reg, rsp_valid_next;
    logic [2:0]  idx_reg, idx_next;

    // shared arithmetic
    logic [63:0] acc_reg, acc_next;
    logic [63:0] ma_reg, ma_next;
    logic [31:0] mb_reg, mb_next;
    logic [63:0] num_reg, num_next;
    logic [34:0] rem_reg, rem_next;
    logic [33:0] dv_reg, dv_next;
    logic [6:0]  bit_reg, bit_next;
    logic [63:0] tmp_reg, tmp_next;
    logic [63:0] whole_reg, whole_next;
    logic [31:0] cur_reg, cur_next;
    logic        do_cmp_reg, do_cmp_next;
    logic        do_ovf_reg, do_ovf_next;
    logic        tgt_ovf_reg, tgt_ovf_next;
    logic [3:0]  scan_reg, scan_next;

    // timer state
    logic [15:0] user_count_reg [NUM_TIMERS];
    logic [15:0] user_count_next [NUM_TIMERS];
    logic [31:0] src_reg [NUM_TIMERS];
    logic [31:0] src_next [NUM_TIMERS];
    logic [8:0]  pre_reg [NUM_TIMERS];
    logic [8:0]  pre_next [NUM_TIMERS];
    logic [31:0] live_reg [NUM_TIMERS];
    logic [31:0] live_next [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] run_reg, run_next;
    logic [NUM_TIMERS-1:0] setup_done_reg, setup_done_next;
    logic [2:0]  smode_reg [NUM_TIMERS];
    logic [2:0]  smode_next [NUM_TIMERS];
    logic [31:0] cbase_reg [NUM_TIMERS];
    logic [31:0] cbase_next [NUM_TIMERS];
    logic [63:0] base_reg [NUM_TIMERS];
    logic [63:0] base_next [NUM_TIMERS];
    logic [31:0] cmpv_reg [NUM_TIMERS];
    logic [31:0] cmpv_next [NUM_TIMERS];
    logic [63:0] cdue_reg [NUM_TIMERS];
    logic [63:0] cdue_next [NUM_TIMERS];
    logic [63:0] odue_reg [NUM_TIMERS];
    logic [63:0] odue_next [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] chs_reg, chs_next;
    logic [NUM_TIMERS-1:0] ohs_reg, ohs_next;
    logic [31:0] hold_reg, hold_next;

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ------------------------------------------------------------------
    // next state, datapath and timer updates
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [3:0]  enc;
        logic [2:0]  fidx;
        logic        fhit;
        logic        found;
        logic [2:0]  sel;
        logic [2:0]  t;
        logic [4:0]  sh;
        logic        is16;
        logic [25:0] hz;
        logic        iop;
        logic [8:0]  pe;
        logic [32:0] modv;
        logic [31:0] d32;
        logic [32:0] delta;
        logic [63:0] r;
        logic [34:0] rsh;
        logic        ge;
        logic [63:0] sv;
        logic [2:0]  sidx;
        logic [31:0] a0;
        logic [31:0] a1;
        logic [31:0] a2;
        logic [31:0] a3;
        logic [63:0] now;

        state_next      = state_reg;
        phase_next      = phase_reg;
        in_next         = in_reg;
        res_next        = res_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg;
        idx_next        = idx_reg;
        acc_next        = acc_reg;
        ma_next         = ma_reg;
        mb_next         = mb_reg;
        num_next        = num_reg;
        rem_next        = rem_reg;
        dv_next         = dv_reg;
        bit_next        = bit_reg;
        tmp_next        = tmp_reg;
        whole_next      = whole_reg;
        cur_next        = cur_reg;
        do_cmp_next     = do_cmp_reg;
        do_ovf_next     = do_ovf_reg;
        tgt_ovf_next    = tgt_ovf_reg;
        scan_next       = scan_reg;
        user_count_next = user_count_reg;
        src_next        = src_reg;
        pre_next        = pre_reg;
        live_next       = live_reg;
        run_next        = run_reg;
        setup_done_next = setup_done_reg;
        smode_next      = smode_reg;
        cbase_next      = cbase_reg;
        base_next       = base_reg;
        cmpv_next       = cmpv_reg;
        cdue_next       = cdue_reg;
        odue_next       = odue_reg;
        chs_next        = chs_reg;
        ohs_next        = ohs_reg;
        hold_next       = hold_reg;

        a0  = in_reg.arg0;
        a1  = in_reg.arg1;
        a2  = in_reg.arg2;
        a3  = in_reg.arg3;
        now = in_reg.now_cycle;
        sh  = {a0[2:0], 2'b00};

        // timer lookup from the id word
        enc  = a0[31:28];
        fidx = (enc >= 4'd1 && enc <= 4'd6) ? 3'(enc - 4'd1) : 3'd0;
        fhit = (enc >= 4'd1) && (enc <= 4'd6) && (user_count_reg[fidx] != 16'h0) &&
               ((a0 & {4'h0, ADDR_MASK}) == (tm_addr(fidx) >> 4));

        // attributes of the timer being worked
        is16 = tm_is16(idx_reg);
        hz   = src_hz(src_reg[idx_reg]);
        iop  = (src_reg[idx_reg] != SRC_PIX) && (src_reg[idx_reg] != SRC_LINE);
        pe   = (pre_reg[idx_reg] == 9'd0) ? 9'd1 : pre_reg[idx_reg];
        modv = is16 ? 33'h10000 : 33'h100000000;

        found = 1'b0;
        sel   = 3'd0;
        t     = 3'd0;
        d32   = 32'h0;
        delta = 33'h0;
        r     = 64'h0;
        rsh   = 35'h0;
        ge    = 1'b0;
        sidx  = 3'd0;
        sv    = 64'h0;

        // response register drains on transfer
        if (rsp_valid_reg && !rsp_stall)
            rsp_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    in_next    = req;
                    res_next   = '{status: ST_OK, value: 32'h0, handled: 1'b1,
                                   next_event: 64'h0};
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                idx_next   = fidx;
                state_next = S_FINISH;
                case (in_reg.op)
                    OP_TABLE, OP_HOLD_REG, OP_READ_FN:
                    begin
                        state_next = S_FINISH;
                    end

                    OP_ALLOC:
                    begin
                        for (int k = 0; k < NUM_TIMERS; k++)
                        begin
                            t = alloc_ord(3'(k));
                            if (!found && user_count_reg[t] == 16'h0 &&
                                (tm_srcmask(t) & a0) != 32'h0 &&
                                tm_width(t) == a1 && {23'h0, tm_maxpre(t)} >= a2)
                            begin
                                found = 1'b1;
                                sel   = t;
                            end
                        end
                        if (found)
                        begin
                            user_count_next[sel] = 16'd1;
                            src_next[sel]        = a0;
                            pre_next[sel]        = (a2 == 32'h0) ? 9'd1 : a2[8:0];
                            base_next[sel]       = now;
                            res_next.value       = make_id(sel);
                        end
                        else
                            res_next.status = ST_NO_TIMER;
                    end

                    OP_REFER:
                    begin
                        for (int k = 0; k < NUM_TIMERS; k++)
                        begin
                            if (!found && user_count_reg[k] != 16'h0 &&
                                live_reg[k] != 32'h0 &&
                                (tm_srcmask(3'(k)) & a0) != 32'h0 &&
                                tm_width(3'(k)) == a1 && (live_reg[k] & a3) == a2)
                            begin
                                found = 1'b1;
                                sel   = 3'(k);
                            end
                        end
                        if (found)
                        begin
                            if (user_count_reg[sel] != COUNT_SAT)
                                user_count_next[sel] = user_count_reg[sel] + 16'd1;
                            res_next.value = make_id(sel);
                        end
                        else
                            res_next.status = ST_NO_TIMER;
                    end

                    OP_NEXT_EVT:
                    begin
                        res_next.next_event = in_reg.fallback_cycle;
                        scan_next           = 4'd0;
                        state_next          = S_SCAN;
                    end

                    OP_SET_HOLD:
                    begin
                        hold_next = (hold_reg & ~(32'hF << sh)) | ({28'h0, a1[3:0]} << sh);
                    end

                    OP_GET_HOLD:
                    begin
                        res_next.value = (hold_reg >> sh) & 32'hF;
                    end

                    OP_FREE, OP_SET_MODE, OP_GET_MODE, OP_SET_CNT, OP_GET_CNT,
                    OP_SET_CMP, OP_GET_CMP, OP_IRQ, OP_MODE_ALT, OP_CMP_HDL,
                    OP_OVF_HDL, OP_SETUP, OP_START, OP_STOP:
                    begin
                        if (!fhit)
                            res_next.status = ST_BAD_ID;
                        else
                        begin
                            case (in_reg.op)
                                OP_FREE:
                                begin
                                    if (user_count_reg[fidx] == 16'd1)
                                    begin
                                        user_count_next[fidx] = 16'h0;
                                        src_next[fidx]        = 32'h0;
                                        pre_next[fidx]        = 9'h0;
                                        live_next[fidx]       = 32'h0;
                                        run_next[fidx]        = 1'b0;
                                        setup_done_next[fidx] = 1'b0;
                                        smode_next[fidx]      = 3'h0;
                                        cbase_next[fidx]      = 32'h0;
                                        base_next[fidx]       = 64'h0;
                                        cmpv_next[fidx]       = 32'h0;
                                        cdue_next[fidx]       = ALL_ONES;
                                        odue_next[fidx]       = ALL_ONES;
                                        chs_next[fidx]        = 1'b0;
                                        ohs_next[fidx]        = 1'b0;
                                    end
                                    else
                                        user_count_next[fidx] = user_count_reg[fidx] - 16'd1;
                                end

                                OP_SET_MODE:
                                begin
                                    if (a1 == 32'h0)
                                        state_next = S_CN_START;
                                    else
                                    begin
                                        live_next[fidx] = a1;
                                        run_next[fidx]  = 1'b1;
                                        base_next[fidx] = now;
                                        state_next      = S_RS_START;
                                    end
                                end

                                OP_GET_MODE, OP_MODE_ALT:
                                begin
                                    res_next.value = live_reg[fidx];
                                end

                                OP_SET_CNT:
                                begin
                                    cbase_next[fidx] = wmask(tm_is16(fidx), a1);
                                    base_next[fidx]  = now;
                                    state_next       = S_RS_START;
                                end

                                OP_GET_CNT:
                                begin
                                    state_next = S_CN_START;
                                end

                                OP_SET_CMP:
                                begin
                                    cmpv_next[fidx] = wmask(tm_is16(fidx), a1);
                                    state_next      = S_RS_START;
                                end

                                OP_GET_CMP:
                                begin
                                    res_next.value = cmpv_reg[fidx];
                                end

                                OP_IRQ:
                                begin
                                    res_next.value = {27'h0, tm_irq(fidx)};
                                end

                                OP_CMP_HDL:
                                begin
                                    if (run_reg[fidx])
                                        res_next.status = ST_NOT_RUN;
                                    else
                                    begin
                                        cmpv_next[fidx] = wmask(tm_is16(fidx), a1);
                                        chs_next[fidx]  = (a2 != 32'h0);
                                    end
                                end

                                OP_OVF_HDL:
                                begin
                                    if (run_reg[fidx])
                                        res_next.status = ST_NOT_RUN;
                                    else
                                        ohs_next[fidx] = (a1 != 32'h0);
                                end

                                OP_SETUP:
                                begin
                                    if (run_reg[fidx])
                                        res_next.status = ST_BUSY;
                                    else if (!(a2 inside {32'd0, 32'd1, 32'd3, 32'd5, 32'd7}))
                                        res_next.status = ST_BAD_MODE;
                                    else if ((tm_srcmask(fidx) & a1) == 32'h0)
                                        res_next.status = ST_BAD_SRC;
                                    else if (a3 == 32'h0 || a3 > {23'h0, tm_maxpre(fidx)})
                                        res_next.status = ST_BAD_PRE;
                                    else
                                    begin
                                        src_next[fidx]        = a1;
                                        smode_next[fidx]      = a2[2:0];
                                        pre_next[fidx]        = a3[8:0];
                                        setup_done_next[fidx] = 1'b1;
                                    end
                                end

                                OP_START:
                                begin
                                    if (run_reg[fidx])
                                        res_next.status = ST_BUSY;
                                    else if (!setup_done_reg[fidx])
                                        res_next.status = ST_UNCONF;
                                    else
                                    begin
                                        cbase_next[fidx] = 32'h0;
                                        base_next[fidx]  = now;
                                        live_next[fidx]  = MODE_RUN_BIT | {29'h0, smode_reg[fidx]};
                                        run_next[fidx]   = 1'b1;
                                        state_next       = S_RS_START;
                                    end
                                end

                                default:
                                begin
                                    // stop
                                    if (!run_reg[fidx])
                                        res_next.status = ST_NOT_RUN;
                                    else
                                        state_next = S_CN_START;
                                end
                            endcase
                        end
                    end

                    default:
                    begin
                        res_next.handled = 1'b0;
                    end
                endcase
            end

            // reschedule: clear due times, then recompute if running
            S_RS_START:
            begin
                cdue_next[idx_reg] = ALL_ONES;
                odue_next[idx_reg] = ALL_ONES;
                state_next = run_reg[idx_reg] ? S_CN_START : S_FINISH;
            end

            // counter value: elapsed cycles times source rate over cpu rate times prescale
            S_CN_START:
            begin
                if (run_reg[idx_reg] && now > base_reg[idx_reg])
                begin
                    acc_next   = 64'h0;
                    ma_next    = now - base_reg[idx_reg];
                    mb_next    = {6'h0, hz};
                    phase_next = PH_CN_P;
                    state_next = S_MUL;
                end
                else
                begin
                    cur_next   = wmask(is16, cbase_reg[idx_reg]);
                    state_next = S_POST;
                end
            end

            // shift-add multiplier, one multiplier bit per cycle
            S_MUL:
            begin
                if (mb_reg == 32'h0)
                    state_next = S_STEP;
                else
                begin
                    if (mb_reg[0])
                        acc_next = acc_reg + ma_reg;
                    ma_next = {ma_reg[62:0], 1'b0};
                    mb_next = {1'b0, mb_reg[31:1]};
                end
            end

            // restoring divider, one quotient bit per cycle
            S_DIV:
            begin
                if (bit_reg == 7'd0)
                    state_next = S_STEP;
                else
                begin
                    rsh      = {rem_reg[33:0], num_reg[63]};
                    ge       = (rsh >= {1'b0, dv_reg});
                    rem_next = ge ? (rsh - {1'b0, dv_reg}) : rsh;
                    num_next = {num_reg[62:0], ge};
                    bit_next = bit_reg - 7'd1;
                end
            end

            // step dispatch after each multiply or divide
            S_STEP:
            begin
                case (phase_reg)
                    PH_CN_P:
                    begin
                        tmp_next   = acc_reg;
                        acc_next   = 64'h0;
                        ma_next    = IOP_HZ;
                        mb_next    = {23'h0, pe};
                        phase_next = PH_CN_D;
                        state_next = S_MUL;
                    end

                    PH_CN_D:
                    begin
                        num_next   = tmp_reg;
                        dv_next    = acc_reg[33:0];
                        rem_next   = 35'h0;
                        bit_next   = 7'd64;
                        phase_next = PH_CN_Q;
                        state_next = S_DIV;
                    end

                    PH_CN_Q:
                    begin
                        cur_next   = wmask(is16, cbase_reg[idx_reg] + num_reg[31:0]);
                        state_next = S_POST;
                    end

                    PH_TT_S:
                    begin
                        if (iop)
                        begin
                            r = (acc_reg == 64'h0) ? 64'd1 : acc_reg;
                            if (tgt_ovf_reg)
                                odue_next[idx_reg] = now + r;
                            else
                                cdue_next[idx_reg] = now + r;
                            state_next = S_RS_NEXT;
                        end
                        else
                        begin
                            num_next   = acc_reg;
                            dv_next    = {8'h0, hz};
                            rem_next   = 35'h0;
                            bit_next   = 7'd64;
                            phase_next = PH_TT_Q1;
                            state_next = S_DIV;
                        end
                    end

                    PH_TT_Q1:
                    begin
                        tmp_next   = {29'h0, rem_reg};
                        acc_next   = 64'h0;
                        ma_next    = num_reg;
                        mb_next    = IOP_HZ[31:0];
                        phase_next = PH_TT_W;
                        state_next = S_MUL;
                    end

                    PH_TT_W:
                    begin
                        whole_next = acc_reg;
                        acc_next   = 64'h0;
                        ma_next    = tmp_reg;
                        mb_next    = IOP_HZ[31:0];
                        phase_next = PH_TT_R;
                        state_next = S_MUL;
                    end

                    PH_TT_R:
                    begin
                        num_next   = acc_reg + {38'h0, hz} - 64'd1;
                        dv_next    = {8'h0, hz};
                        rem_next   = 35'h0;
                        bit_next   = 7'd64;
                        phase_next = PH_TT_Q2;
                        state_next = S_DIV;
                    end

                    default:
                    begin
                        // second quotient: round-up fraction of the conversion
                        r = whole_reg + num_reg;
                        if (r == 64'h0)
                            r = 64'd1;
                        if (tgt_ovf_reg)
                            odue_next[idx_reg] = now + r;
                        else
                            cdue_next[idx_reg] = now + r;
                        state_next = S_RS_NEXT;
                    end
                endcase
            end

            // counter known: read, halt or reschedule
            S_POST:
            begin
                if (in_reg.op == OP_GET_CNT)
                begin
                    res_next.value = cur_reg;
                    state_next     = S_FINISH;
                end
                else if (in_reg.op == OP_STOP || (in_reg.op == OP_SET_MODE && a1 == 32'h0))
                begin
                    cbase_next[idx_reg] = cur_reg;
                    base_next[idx_reg]  = now;
                    run_next[idx_reg]   = 1'b0;
                    live_next[idx_reg]  = 32'h0;
                    cdue_next[idx_reg]  = ALL_ONES;
                    odue_next[idx_reg]  = ALL_ONES;
                    state_next          = S_FINISH;
                end
                else
                begin
                    cbase_next[idx_reg] = cur_reg;
                    base_next[idx_reg]  = now;
                    do_cmp_next         = chs_reg[idx_reg];
                    do_ovf_next         = ohs_reg[idx_reg];
                    state_next          = S_RS_NEXT;
                end
            end

            // pick the next due time to convert: compare, then overflow
            S_RS_NEXT:
            begin
                if (do_cmp_reg)
                begin
                    d32          = wmask(is16, cmpv_reg[idx_reg] - cur_reg);
                    delta        = (d32 == 32'h0) ? modv : {1'b0, d32};
                    do_cmp_next  = 1'b0;
                    tgt_ovf_next = 1'b0;
                    acc_next     = 64'h0;
                    ma_next      = {31'h0, delta};
                    mb_next      = {23'h0, pe};
                    phase_next   = PH_TT_S;
                    state_next   = S_MUL;
                end
                else if (do_ovf_reg)
                begin
                    delta        = modv - {1'b0, cur_reg};
                    do_ovf_next  = 1'b0;
                    tgt_ovf_next = 1'b1;
                    acc_next     = 64'h0;
                    ma_next      = {31'h0, delta};
                    mb_next      = {23'h0, pe};
                    phase_next   = PH_TT_S;
                    state_next   = S_MUL;
                end
                else
                    state_next = S_FINISH;
            end

            // next-event query: one due time per cycle
            S_SCAN:
            begin
                sidx = scan_reg[3:1];
                sv   = scan_reg[0] ? odue_reg[sidx] : cdue_reg[sidx];
                if (sv < res_reg.next_event)
                    res_next.next_event = sv;
                if (scan_reg == 4'd11)
                    state_next = S_FINISH;
                else
                    scan_next = scan_reg + 4'd1;
            end

            S_FINISH:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next       = res_reg;
                    if (res_reg.status != ST_OK)
                        rsp_next.value = 32'h0;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // state register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_CN_P;
            rsp_valid_reg <= 1'b0;
            do_cmp_reg    <= 1'b0;
            do_ovf_reg    <= 1'b0;
            tgt_ovf_reg   <= 1'b0;
            scan_reg      <= 4'h0;
            idx_reg       <= 3'h0;
            run_reg       <= '0;
            setup_done_reg <= '0;
            chs_reg       <= '0;
            ohs_reg       <= '0;
            hold_reg      <= 32'h0;
            for (int k = 0; k < NUM_TIMERS; k++)
            begin
                user_count_reg[k] <= 16'h0;
                src_reg[k]        <= 32'h0;
                pre_reg[k]        <= 9'h0;
                live_reg[k]       <= 32'h0;
                smode_reg[k]      <= 3'h0;
                cbase_reg[k]      <= 32'h0;
                base_reg[k]       <= 64'h0;
                cmpv_reg[k]       <= 32'h0;
                cdue_reg[k]       <= ALL_ONES;
                odue_reg[k]       <= ALL_ONES;
            end
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            rsp_valid_reg  <= rsp_valid_next;
            do_cmp_reg     <= do_cmp_next;
            do_ovf_reg     <= do_ovf_next;
            tgt_ovf_reg    <= tgt_ovf_next;
            scan_reg       <= scan_next;
            idx_reg        <= idx_next;
            run_reg        <= run_next;
            setup_done_reg <= setup_done_next;
            chs_reg        <= chs_next;
            ohs_reg        <= ohs_next;
            hold_reg       <= hold_next;
            user_count_reg <= user_count_next;
            src_reg        <= src_next;
            pre_reg        <= pre_next;
            live_reg       <= live_next;
            smode_reg      <= smode_next;
            cbase_reg      <= cbase_next;
            base_reg       <= base_next;
            cmpv_reg       <= cmpv_next;
            cdue_reg       <= cdue_next;
            odue_reg       <= odue_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        in_reg    <= in_next;
        res_reg   <= res_next;
        rsp_reg   <= rsp_next;
        acc_reg   <= acc_next;
        ma_reg    <= ma_next;
        mb_reg    <= mb_next;
        num_reg   <= num_next;
        rem_reg   <= rem_next;
        dv_reg    <= dv_next;
        bit_reg   <= bit_next;
        tmp_reg   <= tmp_next;
        whole_reg <= whole_next;
        cur_reg   <= cur_next;
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (dv_reg != 34'h0))
        else $error("divider running with zero divisor");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (scan_reg < 4'd12))
        else $error("next-event scan ran past the last due time");

    a_err_value: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status != ST_OK) |-> (rsp.value == 32'h0))
        else $error("error response carries a nonzero value");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CN_START || state_reg == S_RS_START) |-> (idx_reg < 3'd6))
        else $error("timer index out of range");

endmodule

`default_nettype wire
